[rtl/grid_rect_first_fit_allocator_defines.svh]
// ============================================================================
// Grid rectangle allocator assertion macros
// Shared property forms for the checks at the end of the top level.
// ============================================================================
`ifndef GRID_RECT_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define GRID_RECT_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/grff_pkg.sv]
// ============================================================================
// Grid rectangle allocator package
// Request and result payloads, controller command and status groups, codes.
// ============================================================================
package grff_pkg;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 5'd16;

  // Request modes.
  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [4:0] item_width;
    logic [4:0] item_height;
    logic [3:0] at_x;
    logic [3:0] at_y;
    logic       skip_enable;
    logic [3:0] skip_x;
    logic [3:0] skip_y;
    logic [4:0] skip_width;
    logic [4:0] skip_height;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [3:0] place_x;
    logic [3:0] place_y;
    logic       rotated;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic swap;
    logic next_row;
    logic rd_start;
    logic rd_issue;
    logic marking;
    logic eval;
    logic pick;
    logic fail;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_ok;
    logic last_row;
    logic fit_any;
    logic mode_test;
    logic rotated;
  } sts_t;

endpackage

[rtl/grff_ram.sv]
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module grff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/grff_ctrl.sv]
// ============================================================================
// Grid rectangle allocator controller
// Sequences the row scan, window evaluation, rotation retry and marking.
// ============================================================================
module grff_ctrl import grff_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_READ      = 4'd2;
  localparam logic [3:0] S_WAIT      = 4'd3;
  localparam logic [3:0] S_EVAL      = 4'd4;
  localparam logic [3:0] S_PICK      = 4'd5;
  localparam logic [3:0] S_MARK      = 4'd6;
  localparam logic [3:0] S_MARK_WAIT = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // A failing bounds test at the current row ends the pass.
        if (sts.pass_ok) begin
          cmd.rd_start = 1'b1;
          state_next = S_READ;
        end else if (!sts.mode_test && !sts.rotated) begin
          cmd.swap = 1'b1;
        end else begin
          cmd.fail = 1'b1;
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_row) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        if (sts.mode_test) begin
          cmd.pick = 1'b1;
          state_next = S_DONE;
        end else if (sts.fit_any) begin
          cmd.pick = 1'b1;
          cmd.rd_start = 1'b1;
          state_next = S_MARK;
        end else begin
          cmd.next_row = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_MARK: begin
        cmd.rd_issue = 1'b1;
        cmd.marking = 1'b1;
        if (sts.last_row) begin
          state_next = S_MARK_WAIT;
        end
      end
      S_MARK_WAIT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

[rtl/grff_dp.sv]
// ============================================================================
// Grid rectangle allocator datapath
// Occupancy memory, row accumulator, window fit vector and result registers.
// ============================================================================
module grff_dp import grff_pkg::*; #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  req_t                  request,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output res_t                  result
);

  localparam int XW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW = $clog2(MAX_COLS + MAX_ROWS + 64);

  logic [CFG_DATA_W-1:0] grid_w;
  logic [CFG_DATA_W-1:0] grid_h;
  req_t                  req_q;
  logic [4:0]            cur_w;
  logic [4:0]            cur_h;
  logic                  rot_q;
  logic [SW-1:0]         y_q;
  logic [SW-1:0]         r_q;
  logic [MAX_COLS-1:0]   acc;
  logic [MAX_COLS-1:0]   fit_q;
  logic [XW-1:0]         px_q;
  logic                  rd_pend;
  logic                  pend_mark;
  logic [SW-1:0]         rd_row_q;
  logic                  vld_q;
  logic [MAX_ROWS-1:0]   valid;
  res_t                  res_q;

  logic [SW-1:0]         cols;
  logic [SW-1:0]         rows;
  logic [MAX_COLS-1:0]   base;
  logic [MAX_COLS-1:0]   skip_mask;
  logic [MAX_COLS-1:0]   fit_vec;
  logic [XW-1:0]         first_x;
  logic                  fit_at;
  logic [SW-1:0]         rd_addr_full;
  logic [MAX_COLS-1:0]   ram_q;
  logic [MAX_COLS-1:0]   row_eff;
  logic [MAX_COLS-1:0]   row_skip;
  logic [MAX_COLS-1:0]   mark_mask;
  logic                  skip_on;
  logic                  ram_we;
  logic [YW-1:0]         ram_wr_addr;
  logic [YW-1:0]         ram_rd_addr;

  // Grid size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= GRID_SIZE_RESET;
      grid_h <= GRID_SIZE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GRID_WIDTH:  grid_w <= wr_data;
        REG_GRID_HEIGHT: grid_h <= wr_data;
        default: ;
      endcase
    end
  end

  // Grid size in use, clipped to the bitmap.
  assign cols = (SW'(grid_w) > SW'(MAX_COLS)) ? SW'(MAX_COLS) : SW'(grid_w);
  assign rows = (SW'(grid_h) > SW'(MAX_ROWS)) ? SW'(MAX_ROWS) : SW'(grid_h);

  // Request, rectangle size and current row.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= request;
      cur_w <= request.item_width;
      cur_h <= request.item_height;
      rot_q <= 1'b0;
      y_q   <= (request.mode == MODE_TEST) ? SW'(request.at_y) : '0;
    end else if (cmd.swap) begin
      cur_w <= cur_h;
      cur_h <= cur_w;
      rot_q <= 1'b1;
      y_q   <= '0;
    end else if (cmd.next_row) begin
      y_q <= y_q + SW'(1);
    end
  end

  // Row offset within the rectangle.
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      r_q <= '0;
    end else if (cmd.rd_issue) begin
      r_q <= r_q + SW'(1);
    end
  end

  assign rd_addr_full = y_q + r_q;
  assign ram_rd_addr  = YW'(rd_addr_full);

  // Window of the current width at column zero.
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      base[c] = (SW'(c) < SW'(cur_w));
    end
  end

  // Skip rectangle columns, clipped to the bitmap.
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      skip_mask[c] = (SW'(c) >= SW'(req_q.skip_x)) &&
                     (SW'(c) < SW'(req_q.skip_x) + SW'(req_q.skip_width));
    end
  end

  assign skip_on = (req_q.mode == MODE_TEST) && req_q.skip_enable;

  // Row word as read, with unwritten rows free and skip cells freed.
  assign row_eff = vld_q ? ram_q : '0;
  assign row_skip = (skip_on && (rd_row_q >= SW'(req_q.skip_y)) &&
                     (rd_row_q < SW'(req_q.skip_y) + SW'(req_q.skip_height))) ?
                    skip_mask : '0;
  assign mark_mask = base << px_q;

  // Read pipeline tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      pend_mark <= 1'b0;
    end else begin
      rd_pend   <= cmd.rd_issue;
      pend_mark <= cmd.marking;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_row_q <= rd_addr_full;
      vld_q    <= valid[ram_rd_addr];
    end
  end

  // Occupancy of the rows under the rectangle, OR-ed together.
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      acc <= '0;
    end else if (rd_pend && !pend_mark) begin
      acc <= acc | (row_eff & ~row_skip);
    end
  end

  // Read-modify-write of rows while marking.
  assign ram_we      = rd_pend && pend_mark;
  assign ram_wr_addr = YW'(rd_row_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[ram_wr_addr] <= 1'b1;
    end
  end

  grff_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_occ_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (row_eff | mark_mask),
    .rd_en   (cmd.rd_issue),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_q)
  );

  // Fit test of every column position against the accumulated rows.
  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      fit_vec[x] = (SW'(x) + SW'(cur_w) <= cols) && ((acc & (base << x)) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      fit_q <= fit_vec;
    end
  end

  // Leftmost fitting column.
  always_comb begin
    first_x = '0;
    for (int x = MAX_COLS - 1; x >= 0; x--) begin
      if (fit_q[x]) begin
        first_x = XW'(x);
      end
    end
  end

  assign fit_at = (SW'(req_q.at_x) < SW'(MAX_COLS)) && fit_q[XW'(req_q.at_x)];

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      res_q <= '0;
    end else if (cmd.pick) begin
      if (req_q.mode == MODE_TEST) begin
        res_q <= res_t'{found: fit_at, place_x: 4'd0, place_y: 4'd0, rotated: 1'b0};
      end else begin
        res_q.found   <= 1'b1;
        res_q.place_x <= 4'(first_x);
        res_q.place_y <= 4'(y_q);
        res_q.rotated <= rot_q;
        px_q          <= first_x;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    sts.pass_ok   = (cur_w != '0) && (cur_h != '0) && (SW'(cur_w) <= cols) &&
                    (y_q + SW'(cur_h) <= rows);
    sts.last_row  = (r_q == SW'(cur_h) - SW'(1));
    sts.fit_any   = |fit_q;
    sts.mode_test = (req_q.mode == MODE_TEST);
    sts.rotated   = rot_q;
  end

  assign result = res_q;

endmodule

[rtl/grid_rect_first_fit_allocator.sv]
// ============================================================================
// Grid rectangle first-fit allocator
// Keeps a cell occupancy bitmap and places or tests rectangles on it.
// ============================================================================
// Usage: raise start with a request while busy is low; the request is taken
// at that edge and busy stays high until the result is delivered. The result
// is shown for exactly one cycle with done high; there is no back-pressure,
// so the receiver must take it then. busy falls in the cycle after done.
// A test request (mode 1) reads every row under the rectangle before the
// evaluation, and no row when the rectangle cannot lie inside the grid there.
// A place request (mode 0) scans the top-left rows in turn; for each row it
// reads the h rows starting there, h being the height of the orientation being
// tried: one memory read per covered row, then one evaluation of all columns
// of that row at once. Each orientation scans at most grid_height rows; a
// success then marks the occupied rows with a read-modify-write of each.
// The scan speed is set by the single read port of the occupancy memory.
// The grid size registers are written through wr_en, wr_index and wr_data
// while busy is low. Reset frees every cell at once, sets both grid sizes to
// 16 and returns the controller to idle.
// ============================================================================
`include "grid_rect_first_fit_allocator_defines.svh"

module grid_rect_first_fit_allocator import grff_pkg::*; #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  start,
  input  req_t                  request,
  output logic                  busy,
  output logic                  done,
  output res_t                  result
);

  cmd_t cmd;
  sts_t sts;

  // Controller.
  grff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath.
  grff_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .request  (request),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result)
  );

  // Checks on the request flow and result encoding.
  `GRFF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request accepted but not busy")
  `GRFF_ASSERT_NEXT(a_done_idle, done, !busy && !done, "no return to idle after result")
  `GRFF_ASSERT_NOW(a_done_busy, done, busy, "result delivered while idle")
  `GRFF_ASSERT_NOW(a_miss_zero, done && !result.found, (result.place_x == 4'd0) && (result.place_y == 4'd0) && !result.rotated, "miss with nonzero position")

endmodule

[dv/tb_grid_rect_first_fit_allocator.sv]
// ============================================================================
// Grid rectangle first-fit allocator testbench
// Sends place and test requests, predicts each result from a local copy of
// the occupancy bitmap and grid size, and checks every result field by
// field. The grid size changes between phases while the block is idle.
// ============================================================================
module tb_grid_rect_first_fit_allocator;
  import grff_pkg::*;

  localparam int GRID_MAX = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_REQUESTS = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } rect_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  start = 1'b0;
  req_t                  request = '0;
  logic                  busy;
  logic                  done;
  res_t                  result;

  // Local copy of the block's state.
  logic [GRID_MAX-1:0]   cell_taken [GRID_MAX];
  logic [4:0]            grid_cols_cfg;
  logic [4:0]            grid_rows_cfg;
  rect_t                 placed_rects[$];

  req_t                  requests_to_send[$];
  res_t                  results_due[$];
  int                    fail_count = 0;
  int                    stall_cycles = 0;
  bit                    steady_phase = 1'b0;

  grid_rect_first_fit_allocator #(
    .MAX_COLS(GRID_MAX),
    .MAX_ROWS(GRID_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A grid size register above the maximum counts as the maximum.
  function automatic int clamp_dim(logic [4:0] v);
    return (v > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  // Columns lo .. lo+len-1, clipped to the bitmap.
  function automatic logic [GRID_MAX-1:0] col_span(int lo, int len);
    logic [GRID_MAX-1:0] m;
    m = '0;
    for (int i = 0; i < GRID_MAX; i++) m[i] = (i >= lo) && (i < lo + len);
    return m;
  endfunction

  function automatic bit fits_at_point(int x, int y, int w, int h, bit skip,
                                       int sx, int sy, int sw, int sh);
    logic [GRID_MAX-1:0] want;
    logic [GRID_MAX-1:0] freed;
    logic [GRID_MAX-1:0] occ;
    if (w == 0 || h == 0) return 1'b0;
    if (x + w > clamp_dim(grid_cols_cfg) || y + h > clamp_dim(grid_rows_cfg)) return 1'b0;
    want = col_span(x, w);
    freed = skip ? col_span(sx, sw) : '0;
    for (int r = y; r < y + h; r++) begin
      occ = cell_taken[r];
      if (skip && r >= sy && r < sy + sh) occ &= ~freed;
      if ((occ & want) != '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Raster scan of top-left positions, first hit wins.
  function automatic bit first_fit(int w, int h, output int px, output int py);
    px = 0;
    py = 0;
    for (int y = 0; y < clamp_dim(grid_rows_cfg); y++) begin
      for (int x = 0; x < clamp_dim(grid_cols_cfg); x++) begin
        if (fits_at_point(x, y, w, h, 1'b0, 0, 0, 0, 0)) begin
          px = x;
          py = y;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Works out the result of one request and commits any placement.
  function automatic res_t allocate_or_test(req_t q);
    res_t r;
    int   px;
    int   py;
    int   pw;
    int   ph;
    r = '0;
    if (q.mode == MODE_TEST) begin
      r.found = fits_at_point(int'(q.at_x), int'(q.at_y), int'(q.item_width),
                              int'(q.item_height), q.skip_enable,
                              int'(q.skip_x), int'(q.skip_y), int'(q.skip_width),
                              int'(q.skip_height));
    end else begin
      pw = int'(q.item_width);
      ph = int'(q.item_height);
      if (first_fit(pw, ph, px, py)) begin
        r.found = 1'b1;
      end else if (first_fit(ph, pw, px, py)) begin
        r.found = 1'b1;
        r.rotated = 1'b1;
        pw = int'(q.item_height);
        ph = int'(q.item_width);
      end
      if (r.found) begin
        for (int row = py; row < py + ph && row < GRID_MAX; row++) begin
          cell_taken[row] |= col_span(px, pw);
        end
        placed_rects.push_back('{px, py, pw, ph});
        r.place_x = px[3:0];
        r.place_y = py[3:0];
      end
    end
    return r;
  endfunction

  // Random request: mostly small rectangles, tests often aimed at a placed one.
  function automatic req_t random_request();
    logic [63:0] raw;
    req_t        q;
    rect_t       p;
    int          roll;
    int          dx;
    int          dy;
    raw = {$urandom(), $urandom()};
    q = raw[$bits(req_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      q.item_width = 5'($urandom_range(1, 3));
      q.item_height = 5'($urandom_range(1, 3));
    end else if (roll < 90) begin
      q.item_width = 5'($urandom_range(1, 16));
      q.item_height = 5'($urandom_range(1, 16));
    end
    q.mode = ($urandom_range(0, 1) == 1) ? MODE_TEST : MODE_PLACE;
    if (q.mode == MODE_TEST && placed_rects.size() > 0 && $urandom_range(0, 9) < 7) begin
      p = placed_rects[$urandom_range(0, placed_rects.size() - 1)];
      dx = int'($urandom_range(0, 2)) - 1;
      dy = int'($urandom_range(0, 2)) - 1;
      q.at_x = 4'((p.x + dx < 0) ? 0 : p.x + dx);
      q.at_y = 4'((p.y + dy < 0) ? 0 : p.y + dy);
      if ($urandom_range(0, 1) == 1) begin
        q.item_width = 5'(p.w);
        q.item_height = 5'(p.h);
      end
      q.skip_enable = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) != 0) begin
        q.skip_x = 4'(p.x);
        q.skip_y = 4'(p.y);
        q.skip_width = 5'(p.w);
        q.skip_height = 5'(p.h);
      end
    end
    return q;
  endfunction

  // Driver: holds a request until it is taken, then idles a random while.
  always @(posedge clk) begin : driver
    int gap_left;
    bit gap_busy_counts;
    bit drain_hold;
    int roll;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
      gap_busy_counts = 1'b0;
      drain_hold = 1'b0;
    end else begin
      if (start && !busy) begin
        results_due.push_back(allocate_or_test(request));
        roll = $urandom_range(0, 99);
        if (steady_phase || roll < 35) gap_left = 0;
        else if (roll < 80) gap_left = $urandom_range(1, 4);
        else if (roll < 95) gap_left = $urandom_range(5, 40);
        else gap_left = $urandom_range(100, 400);
        gap_busy_counts = 1'($urandom_range(0, 1));
        drain_hold = ($urandom_range(0, 29) == 0);
      end else if (gap_left > 0 && (!busy || gap_busy_counts)) begin
        gap_left--;
      end
      if (start && busy) begin
        // Request still waiting to be taken; keep it on the port.
      end else if (gap_left == 0 && requests_to_send.size() > 0 &&
                   (!drain_hold || results_due.size() == 0)) begin
        request <= requests_to_send.pop_front();
        start <= 1'b1;
        drain_hold = 1'b0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst) begin
      if ((start && !busy) || done || wr_en) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (done) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result: found=%0d x=%0d y=%0d rot=%0d",
                     result.found, result.place_x, result.place_y, result.rotated);
          end
        end else begin
          want = results_due.pop_front();
          if (result.found !== want.found || result.place_x !== want.place_x ||
              result.place_y !== want.place_y || result.rotated !== want.rotated) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("result mismatch: expected found=%0d x=%0d y=%0d rot=%0d, got found=%0d x=%0d y=%0d rot=%0d",
                       want.found, want.place_x, want.place_y, want.rotated,
                       result.found, result.place_x, result.place_y, result.rotated);
            end
          end
        end
      end
    end
  end

  // Watchdog: nothing accepted for too long.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb_grid_rect_first_fit_allocator failed");
    $finish;
  end

  task automatic write_grid(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_GRID_WIDTH) grid_cols_cfg = val;
    else grid_rows_cfg = val;
  endtask

  // Waits until every request is taken and every result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || start || results_due.size() != 0 || busy);
    repeat (3) @(negedge clk);
  endtask

  task automatic queue_request(input logic mode, input int w, input int h, input int ax,
                               input int ay, input bit se, input int sx, input int sy,
                               input int sw, input int sh);
    req_t q;
    q.mode = mode;
    q.item_width = 5'(w);
    q.item_height = 5'(h);
    q.at_x = 4'(ax);
    q.at_y = 4'(ay);
    q.skip_enable = se;
    q.skip_x = 4'(sx);
    q.skip_y = 4'(sy);
    q.skip_width = 5'(sw);
    q.skip_height = 5'(sh);
    requests_to_send.push_back(q);
  endtask

  initial begin
    for (int i = 0; i < GRID_MAX; i++) cell_taken[i] = '0;
    grid_cols_cfg = GRID_SIZE_RESET;
    grid_rows_cfg = GRID_SIZE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Small 4 x 3 grid: zero sizes, rotation, fits, skip rectangle cases.
    write_grid(REG_GRID_WIDTH, 5'd4);
    write_grid(REG_GRID_HEIGHT, 5'd3);
    @(negedge clk);
    queue_request(MODE_PLACE, 0, 3, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_PLACE, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_TEST, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_PLACE, 5, 2, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_PLACE, 1, 4, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_PLACE, 2, 1, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_PLACE, 3, 1, 15, 15, 1, 15, 15, 31, 31);
    queue_request(MODE_TEST, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_TEST, 1, 1, 0, 0, 1, 0, 0, 1, 1);
    queue_request(MODE_TEST, 1, 1, 0, 0, 1, 0, 0, 0, 1);
    queue_request(MODE_TEST, 1, 1, 0, 0, 1, 0, 2, 4, 1);
    queue_request(MODE_TEST, 1, 1, 3, 2, 0, 0, 0, 0, 0);
    queue_request(MODE_TEST, 2, 1, 2, 1, 0, 0, 0, 0, 0);
    queue_request(MODE_TEST, 1, 1, 15, 15, 1, 15, 15, 31, 31);
    queue_request(MODE_TEST, 2, 1, 3, 0, 1, 0, 0, 16, 16);
    queue_request(MODE_PLACE, 31, 31, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_PLACE, 16, 16, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    // Empty grids: nothing fits.
    write_grid(REG_GRID_WIDTH, 5'd0);
    write_grid(REG_GRID_HEIGHT, 5'd31);
    @(negedge clk);
    queue_request(MODE_PLACE, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_TEST, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();
    write_grid(REG_GRID_WIDTH, 5'd31);
    write_grid(REG_GRID_HEIGHT, 5'd0);
    @(negedge clk);
    queue_request(MODE_PLACE, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    // Oversized registers count as the full grid; full-width rows and a rotation.
    write_grid(REG_GRID_HEIGHT, 5'd17);
    @(negedge clk);
    queue_request(MODE_PLACE, 16, 1, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_PLACE, 1, 16, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MODE_TEST, 16, 1, 0, 3, 1, 0, 3, 16, 1);
    wait_idle();

    // Random phases, each with its own grid size.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 6) == 0) write_grid(REG_GRID_WIDTH, 5'($urandom_range(0, 31)));
      else write_grid(REG_GRID_WIDTH, 5'($urandom_range(1, 16)));
      if ($urandom_range(0, 6) == 0) write_grid(REG_GRID_HEIGHT, 5'($urandom_range(0, 31)));
      else write_grid(REG_GRID_HEIGHT, 5'($urandom_range(1, 16)));
      steady_phase = (phase % 4 == 1);
      @(negedge clk);
      for (int n = 0; n < PHASE_REQUESTS; n++) requests_to_send.push_back(random_request());
      wait_idle();
    end
    write_grid(REG_GRID_WIDTH, 5'd1);
    write_grid(REG_GRID_HEIGHT, 5'd16);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("tb_grid_rect_first_fit_allocator passed");
    end else begin
      $display("tb_grid_rect_first_fit_allocator failed");
    end
    $finish;
  end

endmodule

[grid_rect_first_fit_allocator.f]
+incdir+rtl
rtl/grff_pkg.sv
rtl/grff_ram.sv
rtl/grff_ctrl.sv
rtl/grff_dp.sv
rtl/grid_rect_first_fit_allocator.sv
dv/tb_grid_rect_first_fit_allocator.sv
